// ----- src/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// types, constants and lookup functions shared by the playfair pair encryptor
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int SQ_DIM = 5;

   typedef logic [4:0]                letter_type;
   typedef logic [2:0]                sq_index_type;
   typedef logic [4:0][4:0]           row_type;
   typedef logic [4:0][4:0][4:0]      square_type;
   typedef logic [2:0]                csr_index_type;

   localparam letter_type CODE_I    = 5'd8;
   localparam letter_type CODE_J    = 5'd9;
   localparam letter_type PAD_RESET = 5'd23;

   localparam csr_index_type CSR_ROW0 = 3'd0;
   localparam csr_index_type CSR_ROW4 = 3'd4;
   localparam csr_index_type CSR_PAD  = 3'd5;

   // one digraph waiting for encryption
   typedef struct packed {
      letter_type first_letter;
      letter_type second_letter;
      logic       last;
      logic       twice;
   } pair_type;

   typedef struct packed {
      sq_index_type row;
      sq_index_type col;
   } pos_type;

   typedef struct packed {
      letter_type x;
      letter_type y;
   } cipher_type;

   function automatic letter_type fold_j(letter_type c);
      return (c == CODE_J) ? CODE_I : c;
   endfunction

   function automatic sq_index_type next_idx(sq_index_type i);
      return (i == sq_index_type'(SQ_DIM - 1)) ? '0 : i + sq_index_type'(1);
   endfunction

   // first match in row-major order wins, no match gives row 0 column 0
   function automatic pos_type find_pos(square_type sq, letter_type ch);
      pos_type p;
      p = '0;
      for (int r = SQ_DIM - 1; r >= 0; r--) begin
         for (int c = SQ_DIM - 1; c >= 0; c--) begin
            if (sq[r][c] == ch) begin
               p.row = sq_index_type'(r);
               p.col = sq_index_type'(c);
            end
         end
      end
      return p;
   endfunction

   function automatic cipher_type encrypt(square_type sq, letter_type a, letter_type b);
      pos_type    pa;
      pos_type    pb;
      cipher_type o;
      pa = find_pos(sq, a);
      pb = find_pos(sq, b);
      if (pa.row == pb.row) begin
         o.x = sq[pa.row][next_idx(pa.col)];
         o.y = sq[pb.row][next_idx(pb.col)];
      end else if (pa.col == pb.col) begin
         o.x = sq[next_idx(pa.row)][pa.col];
         o.y = sq[next_idx(pb.row)][pb.col];
      end else begin
         o.x = sq[pa.row][pb.col];
         o.y = sq[pb.row][pa.col];
      end
      return o;
   endfunction

endpackage

// ----- src/pfe_front.sv -----
// ----------------------------------------------------------------------------
// pfe_front
// pairs incoming letters into digraphs and pushes them to the pair queue
// ----------------------------------------------------------------------------
module pfe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pfe_pkg::letter_type req_plain_letter,
   input  logic                req_is_final,
   input  pfe_pkg::letter_type pad_letter,
   output logic                push_valid,
   input  logic                push_ready,
   output pfe_pkg::pair_type   push_data
);
   import pfe_pkg::*;

   letter_type held_letter_ff, held_letter_in;
   logic       held_valid_ff, held_valid_in;
   letter_type letter;
   letter_type pad;
   logic       accept;

   always_comb begin
      letter         = fold_j(req_plain_letter);
      pad            = fold_j(pad_letter);
      req_ready      = push_ready;
      accept         = req_valid && push_ready;
      push_valid     = 1'b0;
      push_data      = '{first_letter: held_letter_ff, second_letter: letter,
                         last: req_is_final, twice: 1'b0};
      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      if (accept) begin
         if (!held_valid_ff) begin
            if (req_is_final) begin
               // odd final letter, pad it
               push_valid = 1'b1;
               push_data  = '{first_letter: letter, second_letter: pad,
                              last: 1'b1, twice: 1'b0};
            end else begin
               held_valid_in  = 1'b1;
               held_letter_in = letter;
            end
         end else if (held_letter_ff == letter) begin
            // doubled letter: (held, pad), and again for the final one
            push_valid    = 1'b1;
            push_data     = '{first_letter: held_letter_ff, second_letter: pad,
                              last: req_is_final, twice: req_is_final};
            held_valid_in = !req_is_final;
         end else begin
            push_valid    = 1'b1;
            held_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_letter_ff <= held_letter_in;
   end

endmodule

// ----- src/pfe_queue.sv -----
// ----------------------------------------------------------------------------
// pfe_queue
// short first-in first-out queue of digraphs between front and back
// ----------------------------------------------------------------------------
module pfe_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pfe_pkg::pair_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output pfe_pkg::pair_type pop_data
);
   import pfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pair_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      push_ready = (count_ff != CNT_W'(DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/pfe_back.sv -----
// ----------------------------------------------------------------------------
// pfe_back
// encrypts a digraph per cycle by key square into rsp register, unless stalled
// ----------------------------------------------------------------------------
module pfe_back (
   input  logic                clock,
   input  logic                reset,
   input  pfe_pkg::square_type square,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  pfe_pkg::pair_type   pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pfe_pkg::letter_type rsp_cipher_first,
   output logic [4:0]          rsp_cipher_second,
   output logic                rsp_final_pair
);
   import pfe_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       dup_ff, dup_in;
   logic       last_ff, last_in;
   cipher_type cipher_ff, cipher_in;
   logic       load;
   logic       repeat_out;

   always_comb begin
      // a doubled final letter repeats the same cipher pair, now marked last
      repeat_out   = out_valid_ff && rsp_ready && dup_ff;
      pop_ready    = (!out_valid_ff || rsp_ready) && !dup_ff;
      load         = pop_ready;
      out_valid_in = out_valid_ff;
      dup_in       = dup_ff;
      last_in      = last_ff;
      cipher_in    = cipher_ff;
      if (repeat_out) begin
         last_in = 1'b1;
         dup_in  = 1'b0;
      end else if (load) begin
         out_valid_in = pop_valid;
         if (pop_valid) begin
            cipher_in = encrypt(square, pop_data.first_letter, pop_data.second_letter);
            last_in   = pop_data.last && !pop_data.twice;
            dup_in    = pop_data.twice;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         dup_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         dup_ff       <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      cipher_ff <= cipher_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_cipher_first  = cipher_ff.x;
   assign rsp_cipher_second = cipher_ff.y;
   assign rsp_final_pair    = last_ff;

endmodule

// ----- src/playfair_pair_encryptor.sv -----
// ----------------------------------------------------------------------------
// playfair_pair_encryptor
// playfair digraph encryption of a letter stream against a loaded key square
// ----------------------------------------------------------------------------
// usage
//   req channel: one plaintext letter per transaction (A=0..Z=25, J read as I)
//     with is_final on the last letter of a message
//   rsp channel: one transaction per digraph, two cipher letters and
//     final_pair on the last digraph of the message
//   csr channel: index 0..4 loads key square rows, index 5 the pad letter;
//     always ready, write only while no letter is in flight
// timing
//   one letter per cycle sustained while the queue has room; the letter that
//   closes a digraph writes it to the queue, then it is encrypted into the
//   rsp register; a doubled final letter yields two transactions;
//   the back end drains a digraph per cycle from the pair queue unless stalled
// reset
//   square rows clear to zero, pad letter to X, no letter pending, queue empty
// stall
//   a stalled rsp holds its transaction; the queue keeps taking letters until
//   QUEUE_DEPTH digraphs wait, then req_ready drops
// ----------------------------------------------------------------------------
module playfair_pair_encryptor #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // letter input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pfe_pkg::letter_type    req_plain_letter,
   input  logic                   req_is_final,
   // digraph result
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pfe_pkg::letter_type    rsp_cipher_first,
   output pfe_pkg::letter_type    rsp_cipher_second,
   output logic                   rsp_final_pair,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  pfe_pkg::csr_index_type csr_index,
   input  pfe_pkg::row_type       csr_wdata
);
   import pfe_pkg::*;

   // key square and pad letter
   square_type square_ff, square_in;
   letter_type pad_ff, pad_in;

   // front to queue
   logic       push_valid;
   logic       push_ready;
   pair_type   push_data;

   // queue to back
   logic       pop_valid;
   logic       pop_ready;
   pair_type   pop_data;

   assign csr_ready = 1'b1;

   // register write decode, indexes beyond the pad letter are dropped
   always_comb begin
      square_in = square_ff;
      pad_in    = pad_ff;
      if (csr_valid) begin
         case (csr_index) inside
            [CSR_ROW0:CSR_ROW4]: square_in[csr_index] = csr_wdata;
            // pad letter sits in the low five bits of the write data
            CSR_PAD:             pad_in = csr_wdata[0];
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= '0;
         pad_ff    <= PAD_RESET;
      end else begin
         square_ff <= square_in;
         pad_ff    <= pad_in;
      end
   end

   // front: pending letter and digraph forming
   pfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_plain_letter (req_plain_letter),
      .req_is_final     (req_is_final),
      .pad_letter       (pad_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // digraphs waiting for the encrypt stage
   pfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: square lookup, playfair rules, result register
   pfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .square            (square_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cipher_first  (rsp_cipher_first),
      .rsp_cipher_second (rsp_cipher_second),
      .rsp_final_pair    (rsp_final_pair)
   );

endmodule

// ----- src/pfe_checker.sv -----
// ----------------------------------------------------------------------------
// pfe_checker
// port-level checks on the playfair pair encryptor, bound to the top level
// ----------------------------------------------------------------------------
module pfe_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input pfe_pkg::letter_type rsp_cipher_first,
   input pfe_pkg::letter_type rsp_cipher_second,
   input logic                rsp_final_pair,
   input logic                csr_ready
);

   // no result survives reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // queue is empty after reset, so letters are taken at once
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low right after reset");

   // register port never back-pressures
   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr_ready low");

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cipher_first)
         && $stable(rsp_cipher_second) && $stable(rsp_final_pair))
      else $error("stalled rsp transaction changed");

endmodule

bind playfair_pair_encryptor pfe_checker u_pfe_checker (.*);
